// File: rtl/core/abs_pkg.sv
package abs_pkg;

    // default number of queued messages
    localparam int QUEUE_DEPTH_DEF = 64;

    // width of the sent checksum: seq bit plus 20 byte values
    localparam int SUM_W = 13;

    // event codes
    typedef enum logic [1:0] {
        FUNC_MESSAGE = 2'd0,
        FUNC_PACKET  = 2'd1,
        FUNC_EXPIRY  = 2'd2
    } func_t;

    // timer commands
    typedef enum logic [1:0] {
        TIMER_NONE    = 2'd0,
        TIMER_START   = 2'd1,
        TIMER_STOP    = 2'd2,
        TIMER_RESTART = 2'd3
    } timer_t;

    // where the packet of a result comes from
    typedef enum logic [1:0] {
        SRC_NONE  = 2'd0,
        SRC_INPUT = 2'd1,
        SRC_QUEUE = 2'd2,
        SRC_LAST  = 2'd3
    } src_t;

    // one 20-byte message, byte 0 in low[7:0]
    typedef struct packed {
        logic [31:0] high;
        logic [63:0] mid;
        logic [63:0] low;
    } msg_t;

    // sum of the 20 payload bytes as an adder tree
    function automatic logic [SUM_W-1:0] byte_sum(input msg_t m);
        logic [159:0]     flat;
        logic [8:0]       pair [10];
        logic [9:0]       quad [5];
        logic [SUM_W-1:0] total;
        flat = m;
        for (int i = 0; i < 10; i++) begin
            pair[i] = {1'b0, flat[16*i +: 8]} + {1'b0, flat[16*i+8 +: 8]};
        end
        for (int j = 0; j < 5; j++) begin
            quad[j] = {1'b0, pair[2*j]} + {1'b0, pair[2*j+1]};
        end
        total = SUM_W'(quad[0]) + SUM_W'(quad[1]) + SUM_W'(quad[2])
              + SUM_W'(quad[3]) + SUM_W'(quad[4]);
        return total;
    endfunction

endpackage

// File: rtl/core/alternating_bit_sender.sv
// alternating-bit sender, stop-and-wait with one sequence bit
//
// event channel (event_valid / event_stall): one protocol event per transfer,
// func selects a message from above, a packet from the network or a timer
// expiry; payload and packet header fields ride with it
// result channel (result_valid / result_stall): exactly one result per event,
// carrying the packet to send (if any), the timer command and the drop flag
//
// pipeline: event register, decide stage (queue pointers, ack check, queue
// memory write or read), assemble stage (payload select, checksum), result
// register; throughput is one event per cycle while the result channel does
// not stall; the queue memory has one write and one read port and each event
// uses at most one of them, in the decide stage
// reset empties the queue, clears the sequence bit and the in-flight flag
// and sets the last packet to all zero; queue contents are not cleared, so
// the block takes events right after reset
// when the receiver stalls, the result register holds; events are still
// taken until the event and assemble stages are full as well
module alternating_bit_sender #(
    parameter int QUEUE_DEPTH = abs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    // event channel
    input  logic               event_valid,
    output logic               event_stall,
    input  logic [1:0]         func,
    input  logic [63:0]        payload_low,
    input  logic [63:0]        payload_mid,
    input  logic [31:0]        payload_high,
    input  logic signed [31:0] in_seq_number,
    input  logic signed [31:0] in_ack_number,
    input  logic signed [31:0] in_checksum,
    // result channel
    output logic               result_valid,
    input  logic               result_stall,
    output logic               send_valid,
    output logic               out_seq_number,
    output logic [12:0]        out_checksum,
    output logic [63:0]        out_payload_low,
    output logic [63:0]        out_payload_mid,
    output logic [31:0]        out_payload_high,
    output logic [1:0]         timer_action,
    output logic               dropped
);
    import abs_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    // pointer step with wrap at the queue depth
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
    endfunction

    // handshake between stages
    logic out_free;
    logic s2_ready;
    logic s2_move;
    logic s1_ready;
    logic s1_move;
    logic ev_take;

    // event register
    logic        s1_valid_reg;
    logic [1:0]  s1_func_reg;
    msg_t        s1_msg_reg;
    logic [31:0] s1_seq_reg;
    logic [31:0] s1_ack_reg;
    logic [31:0] s1_chk_reg;

    // protocol state
    logic             cur_seq_reg,  cur_seq_next;
    logic             awaiting_reg, awaiting_next;
    logic [PTR_W-1:0] head_reg,     head_next;
    logic [PTR_W-1:0] tail_reg,     tail_next;
    logic [CNT_W-1:0] count_reg,    count_next;

    // last sent packet
    logic             last_seq_reg,  last_seq_next;
    logic [SUM_W-1:0] last_sum_reg,  last_sum_next;
    msg_t             last_msg_reg,  last_msg_next;

    // assemble stage
    logic   s2_valid_reg;
    src_t   s2_src_reg,   s2_src_next;
    logic   s2_seq_reg,   s2_seq_next;
    timer_t s2_timer_reg, s2_timer_next;
    logic   s2_drop_reg,  s2_drop_next;
    msg_t   s2_msg_reg;

    // result register
    logic             res_valid_reg;
    logic             res_send_reg;
    logic             res_seq_reg;
    logic [SUM_W-1:0] res_sum_reg;
    msg_t             res_msg_reg;
    timer_t           res_timer_reg;
    logic             res_drop_reg;

    // queue memory port signals
    logic wr_en;
    logic rd_en;
    msg_t rd_data;

    // decide stage signals
    logic [31:0] s1_sum;
    logic        ack_ok;

    // assemble stage signals
    logic             s2_send;
    logic             s2_seq_out;
    msg_t             s2_msg_out;
    logic [SUM_W-1:0] s2_sum_out;

    assign out_free    = !res_valid_reg || !result_stall;
    assign s2_ready    = !s2_valid_reg || out_free;
    assign s2_move     = s2_valid_reg && out_free;
    assign s1_ready    = !s1_valid_reg || s2_ready;
    assign s1_move     = s1_valid_reg && s2_ready;
    assign event_stall = !s1_ready;
    assign ev_take     = event_valid && !event_stall;

    // ---------------------------------------------------------------
    // event register
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= event_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ev_take)
        begin
            s1_func_reg     <= func;
            s1_msg_reg.low  <= payload_low;
            s1_msg_reg.mid  <= payload_mid;
            s1_msg_reg.high <= payload_high;
            s1_seq_reg      <= $unsigned(in_seq_number);
            s1_ack_reg      <= $unsigned(in_ack_number);
            s1_chk_reg      <= $unsigned(in_checksum);
        end
    end

    // ---------------------------------------------------------------
    // decide stage: ack check, queue bookkeeping, memory access
    // ---------------------------------------------------------------
    // a packet counts as an ack only if its checksum matches and it
    // acknowledges the current bit
    assign s1_sum = s1_seq_reg + s1_ack_reg + 32'(byte_sum(s1_msg_reg));
    assign ack_ok = (s1_sum == s1_chk_reg) && (s1_ack_reg == {31'b0, cur_seq_reg});

    always_comb
    begin
        cur_seq_next  = cur_seq_reg;
        awaiting_next = awaiting_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        wr_en         = 1'b0;
        rd_en         = 1'b0;
        s2_src_next   = SRC_NONE;
        s2_seq_next   = 1'b0;
        s2_timer_next = TIMER_NONE;
        s2_drop_next  = 1'b0;
        if (s1_move)
        begin
            unique case (s1_func_reg)
                FUNC_MESSAGE:
                begin
                    if (count_reg == CNT_FULL)
                    begin
                        s2_drop_next = 1'b1;
                    end
                    else if (awaiting_reg)
                    begin
                        // packet in flight: park the message
                        wr_en      = 1'b1;
                        tail_next  = ptr_inc(tail_reg);
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        // idle means an empty queue: send straight through
                        awaiting_next = 1'b1;
                        head_next     = ptr_inc(head_reg);
                        tail_next     = ptr_inc(tail_reg);
                        s2_src_next   = SRC_INPUT;
                        s2_seq_next   = cur_seq_reg;
                        s2_timer_next = TIMER_START;
                    end
                end
                FUNC_PACKET:
                begin
                    if (ack_ok)
                    begin
                        awaiting_next = 1'b0;
                        cur_seq_next  = !cur_seq_reg;
                        if (count_reg != '0)
                        begin
                            // fetch the front message, it leaves with the new bit
                            rd_en         = 1'b1;
                            head_next     = ptr_inc(head_reg);
                            count_next    = count_reg - CNT_W'(1);
                            awaiting_next = 1'b1;
                            s2_src_next   = SRC_QUEUE;
                            s2_seq_next   = !cur_seq_reg;
                            s2_timer_next = TIMER_RESTART;
                        end
                        else
                        begin
                            s2_timer_next = TIMER_STOP;
                        end
                    end
                end
                FUNC_EXPIRY:
                begin
                    s2_src_next   = SRC_LAST;
                    s2_timer_next = TIMER_START;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_seq_reg  <= 1'b0;
            awaiting_reg <= 1'b0;
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
        end
        else
        begin
            cur_seq_reg  <= cur_seq_next;
            awaiting_reg <= awaiting_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            count_reg    <= count_next;
        end
    end

    // one event per cycle in the decide stage, so a write and a read never
    // meet in the same cycle; a read after a write sees the new entry
    abs_queue_mem #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (tail_reg),
        .wr_data (s1_msg_reg),
        .rd_en   (rd_en),
        .rd_addr (head_reg),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            s2_src_reg   <= s2_src_next;
            s2_seq_reg   <= s2_seq_next;
            s2_timer_reg <= s2_timer_next;
            s2_drop_reg  <= s2_drop_next;
            s2_msg_reg   <= s1_msg_reg;
        end
    end

    // ---------------------------------------------------------------
    // assemble stage: pick the payload and build the checksum
    // ---------------------------------------------------------------
    always_comb
    begin
        s2_send    = 1'b1;
        s2_msg_out = '0;
        unique case (s2_src_reg)
            SRC_INPUT: s2_msg_out = s2_msg_reg;
            SRC_QUEUE: s2_msg_out = rd_data;
            SRC_LAST:  s2_msg_out = last_msg_reg;
            SRC_NONE:  s2_send    = 1'b0;
            default:   s2_send    = 1'b0;
        endcase
        // retransmit repeats the stored header, a fresh packet gets a new sum
        if (s2_src_reg == SRC_LAST)
        begin
            s2_seq_out = last_seq_reg;
            s2_sum_out = last_sum_reg;
        end
        else if (s2_send)
        begin
            s2_seq_out = s2_seq_reg;
            s2_sum_out = SUM_W'(s2_seq_reg) + byte_sum(s2_msg_out);
        end
        else
        begin
            s2_seq_out = 1'b0;
            s2_sum_out = '0;
        end
    end

    always_comb
    begin
        last_seq_next = last_seq_reg;
        last_sum_next = last_sum_reg;
        last_msg_next = last_msg_reg;
        if (s2_move && (s2_src_reg == SRC_INPUT || s2_src_reg == SRC_QUEUE))
        begin
            last_seq_next = s2_seq_out;
            last_sum_next = s2_sum_out;
            last_msg_next = s2_msg_out;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_seq_reg <= 1'b0;
            last_sum_reg <= '0;
            last_msg_reg <= '0;
        end
        else
        begin
            last_seq_reg <= last_seq_next;
            last_sum_reg <= last_sum_next;
            last_msg_reg <= last_msg_next;
        end
    end

    // ---------------------------------------------------------------
    // result register
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            res_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_move)
        begin
            res_send_reg  <= s2_send;
            res_seq_reg   <= s2_seq_out;
            res_sum_reg   <= s2_sum_out;
            res_msg_reg   <= s2_msg_out;
            res_timer_reg <= s2_timer_reg;
            res_drop_reg  <= s2_drop_reg;
        end
    end

    assign result_valid     = res_valid_reg;
    assign send_valid       = res_send_reg;
    assign out_seq_number   = res_seq_reg;
    assign out_checksum     = res_sum_reg;
    assign out_payload_low  = res_msg_reg.low;
    assign out_payload_mid  = res_msg_reg.mid;
    assign out_payload_high = res_msg_reg.high;
    assign timer_action     = res_timer_reg;
    assign dropped          = res_drop_reg;

endmodule

// File: rtl/core/abs_queue_mem.sv
module abs_queue_mem #(
    parameter int  DEPTH = abs_pkg::QUEUE_DEPTH_DEF,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [PTR_W-1:0]  wr_addr,
    input  abs_pkg::msg_t     wr_data,
    input  logic              rd_en,
    input  logic [PTR_W-1:0]  rd_addr,
    output abs_pkg::msg_t     rd_data
);
    import abs_pkg::*;

    msg_t mem [DEPTH];
    msg_t rd_data_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/abs_checker.sv
module abs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        result_valid,
    input logic        result_stall,
    input logic        send_valid,
    input logic        out_seq_number,
    input logic [12:0] out_checksum,
    input logic [63:0] out_payload_low,
    input logic [63:0] out_payload_mid,
    input logic [31:0] out_payload_high,
    input logic [1:0]  timer_action,
    input logic        dropped
);
    import abs_pkg::*;

    msg_t             sent_msg;
    logic [SUM_W-1:0] sent_sum;

    assign sent_msg = {out_payload_high, out_payload_mid, out_payload_low};
    assign sent_sum = SUM_W'(out_seq_number) + byte_sum(sent_msg);

    // a stalled result keeps its contents
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(send_valid)
            && $stable(out_checksum) && $stable(timer_action) && $stable(dropped))
        else $error("result changed while stalled");

    // every sent packet, fresh or repeated, carries a matching checksum
    a_sum: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && send_valid |-> out_checksum == sent_sum)
        else $error("checksum does not match sent packet");

    // no packet means an all-zero packet
    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !send_valid |-> out_checksum == '0 && !out_seq_number
            && out_payload_low == '0 && out_payload_mid == '0 && out_payload_high == '0)
        else $error("packet fields set without a send");

    // a send always arms the timer and arming always comes with a send
    a_timer: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> send_valid
            == (timer_action == TIMER_START || timer_action == TIMER_RESTART))
        else $error("timer command does not fit the send");

    // a dropped message has no other effect
    a_drop: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && dropped |-> !send_valid && timer_action == TIMER_NONE)
        else $error("drop came with a send or timer command");

endmodule

bind alternating_bit_sender abs_checker u_abs_checker (.*);

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import abs_pkg::*;

    localparam int QUEUE_DEPTH = QUEUE_DEPTH_DEF;
    localparam int ITEMS = 950;
    // cycles with no transfer on either channel before the run is given up
    localparam int IDLE_LIMIT = 3000;
    // pipeline is 3 deep, so a short settle covers any straggling result
    localparam int SETTLE_CYCLES = 20;
    // event code outside the defined set, the block must ignore it
    localparam logic [1:0] FUNC_UNKNOWN = 2'd3;

    // one protocol event as driven on the event channel
    typedef struct packed {
        logic [1:0]  func;
        msg_t        msg;
        logic [31:0] seq;
        logic [31:0] ack;
        logic [31:0] chk;
    } event_t;

    // one result as seen on the result channel
    typedef struct packed {
        logic        send;
        logic        seq_bit;
        logic [12:0] csum;
        msg_t        msg;
        timer_t      timer;
        logic        drop;
    } result_t;

    // one row of the directed table
    typedef struct {
        event_t  ev;
        bit      fix_chk;   // fill in the correct checksum at drive time
        bit      typed;     // want holds the result read off by hand
        result_t want;
    } row_t;

    logic               clk;
    logic               rst_n;
    logic               event_valid;
    logic               event_stall;
    logic [1:0]         func;
    logic [63:0]        payload_low;
    logic [63:0]        payload_mid;
    logic [31:0]        payload_high;
    logic signed [31:0] in_seq_number;
    logic signed [31:0] in_ack_number;
    logic signed [31:0] in_checksum;
    logic               result_valid;
    logic               result_stall;
    logic               send_valid;
    logic               out_seq_number;
    logic [12:0]        out_checksum;
    logic [63:0]        out_payload_low;
    logic [63:0]        out_payload_mid;
    logic [31:0]        out_payload_high;
    logic [1:0]         timer_action;
    logic               dropped;

    alternating_bit_sender #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .event_valid     (event_valid),
        .event_stall     (event_stall),
        .func            (func),
        .payload_low     (payload_low),
        .payload_mid     (payload_mid),
        .payload_high    (payload_high),
        .in_seq_number   (in_seq_number),
        .in_ack_number   (in_ack_number),
        .in_checksum     (in_checksum),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .send_valid      (send_valid),
        .out_seq_number  (out_seq_number),
        .out_checksum    (out_checksum),
        .out_payload_low (out_payload_low),
        .out_payload_mid (out_payload_mid),
        .out_payload_high(out_payload_high),
        .timer_action    (timer_action),
        .dropped         (dropped)
    );

    // ------------------------------------------------------------------
    // sender model state, advanced once per accepted event transfer
    // ------------------------------------------------------------------
    logic    cur_bit;        // sequence bit of the next new packet
    logic    in_flight;      // a packet is out and not yet acknowledged
    logic    last_bit;       // header of the last packet sent
    logic [12:0] last_sum;
    msg_t    last_msg;
    msg_t    pending_msgs[$];

    // results still owed by the block, oldest first
    result_t expected_results[$];

    row_t    directed_rows[$];
    int      mismatch_count = 0;
    int      accepted_items = 0;
    int      burst_left = 0;
    int      idle_cycles = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // checksum and prediction
    // ------------------------------------------------------------------

    // plain sum of the 20 payload bytes
    function automatic logic [12:0] sum_of_bytes(msg_t m);
        logic [159:0] flat;
        logic [12:0]  total;
        flat = m;
        total = '0;
        for (int b = 0; b < 20; b++)
        begin
            total += 13'(flat[8*b +: 8]);
        end
        return total;
    endfunction

    // 32-bit wrapping checksum an uncorrupted packet carries
    function automatic logic [31:0] good_checksum(event_t ev);
        return ev.seq + ev.ack + 32'(sum_of_bytes(ev.msg));
    endfunction

    function automatic result_t make_result(logic send, logic seq_bit, logic [12:0] csum,
                                            msg_t m, timer_t t);
        result_t r;
        r = '0;
        r.send = send;
        r.seq_bit = seq_bit;
        r.csum = csum;
        r.msg = m;
        r.timer = t;
        return r;
    endfunction

    // retransmission of whatever went out last
    function automatic result_t last_packet();
        return make_result(1'b1, last_bit, last_sum, last_msg, TIMER_NONE);
    endfunction

    // send the front message when nothing is in flight
    function automatic bit send_front_msg(inout result_t r);
        if (pending_msgs.size() == 0 || in_flight)
            return 1'b0;
        last_msg = pending_msgs.pop_front();
        last_bit = cur_bit;
        last_sum = 13'(last_bit) + sum_of_bytes(last_msg);
        in_flight = 1'b1;
        r = last_packet();
        return 1'b1;
    endfunction

    // one event through the sender, returns the result it owes
    function automatic result_t advance_sender(event_t ev);
        result_t r;
        r = '0;
        case (ev.func)
            FUNC_MESSAGE:
            begin
                if (pending_msgs.size() >= QUEUE_DEPTH)
                    r.drop = 1'b1;
                else
                begin
                    pending_msgs.push_back(ev.msg);
                    if (send_front_msg(r))
                        r.timer = TIMER_START;
                end
            end
            FUNC_PACKET:
            begin
                // ack must be uncorrupted and carry exactly the current bit
                if (good_checksum(ev) == ev.chk && ev.ack == {31'b0, cur_bit})
                begin
                    in_flight = 1'b0;
                    cur_bit = ~cur_bit;
                    r.timer = send_front_msg(r) ? TIMER_RESTART : TIMER_STOP;
                end
            end
            FUNC_EXPIRY:
            begin
                // retransmits even when idle, all zero right after reset
                r = last_packet();
                r.timer = TIMER_START;
            end
            default:
            begin
                // unknown codes leave the result at zero
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus builders
    // ------------------------------------------------------------------

    // mostly full random bytes, now and then the all-zero and all-one extremes
    function automatic msg_t random_msg();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom, $urandom, $urandom, $urandom};
        endcase
    endfunction

    function automatic event_t random_event(logic [1:0] f);
        event_t ev;
        ev.func = f;
        ev.msg = random_msg();
        ev.seq = $urandom;
        ev.ack = $urandom;
        ev.chk = $urandom;
        return ev;
    endfunction

    // well-formed ack packet for the given bit
    function automatic event_t good_ack_event(logic ack_bit);
        event_t ev;
        ev = random_event(FUNC_PACKET);
        ev.ack = {31'b0, ack_bit};
        ev.chk = good_checksum(ev);
        return ev;
    endfunction

    // packets and codes the sender has to throw away
    function automatic event_t noise_event();
        event_t ev;
        case ($urandom_range(0, 3))
            0:
            begin
                // one bit flipped in transit
                ev = good_ack_event(cur_bit);
                case ($urandom_range(0, 3))
                    0: ev.chk[$urandom_range(0, 31)] ^= 1'b1;
                    1: ev.seq[$urandom_range(0, 31)] ^= 1'b1;
                    2: ev.ack[$urandom_range(0, 31)] ^= 1'b1;
                    default: ev.msg ^= msg_t'(160'(1) << $urandom_range(0, 159));
                endcase
            end
            1: ev = random_event(FUNC_PACKET);
            2: ev = good_ack_event(~cur_bit);
            default: ev = random_event(FUNC_UNKNOWN);
        endcase
        return ev;
    endfunction

    // everyday traffic: messages, good acks, expiries, some garbage
    function automatic event_t mixed_event();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            return random_event(FUNC_MESSAGE);
        else if (pick < 75)
            return good_ack_event(cur_bit);
        else if (pick < 85)
            return random_event(FUNC_EXPIRY);
        else
            return noise_event();
    endfunction

    task automatic add_row(logic [1:0] f, msg_t m, logic [31:0] s, logic [31:0] a,
                           logic [31:0] c, bit fix_chk, bit typed, result_t want);
        row_t row;
        row.ev = '{func: f, msg: m, seq: s, ack: a, chk: c};
        row.fix_chk = fix_chk;
        row.typed = typed;
        row.want = want;
        directed_rows.push_back(row);
    endtask

    // ------------------------------------------------------------------
    // event channel driver, bursts of transfers with random gaps
    // ------------------------------------------------------------------
    task automatic run_item(event_t ev, bit typed, result_t want);
        result_t predicted;
        int      gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30)
                                              : $urandom_range(1, 4);
            // now and then a long stretch with no gaps at all
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 20);
            event_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        burst_left--;
        event_valid   <= 1'b1;
        func          <= ev.func;
        payload_low   <= ev.msg.low;
        payload_mid   <= ev.msg.mid;
        payload_high  <= ev.msg.high;
        in_seq_number <= ev.seq;
        in_ack_number <= ev.ack;
        in_checksum   <= ev.chk;
        @(posedge clk);
        while (event_stall) @(posedge clk);
        // transfer done at this edge
        predicted = advance_sender(ev);
        expected_results.push_back(typed ? want : predicted);
        accepted_items++;
    endtask

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        mismatch_count++;
        $display("[%0t] mismatch %0d on %s: got %h, want %h",
                 $realtime, mismatch_count, what, got, want);
    endtask

    task automatic check_field(string what, logic [63:0] got, logic [63:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    task automatic check_result(result_t got, result_t want);
        check_field("send_valid", got.send, want.send);
        check_field("out_seq_number", got.seq_bit, want.seq_bit);
        check_field("out_checksum", got.csum, want.csum);
        check_field("out_payload_low", got.msg.low, want.msg.low);
        check_field("out_payload_mid", got.msg.mid, want.msg.mid);
        check_field("out_payload_high", got.msg.high, want.msg.high);
        check_field("timer_action", got.timer, want.timer);
        check_field("dropped", got.drop, want.drop);
    endtask

    // result channel: check every transfer, stall on a pattern of its own
    initial
    begin
        result_t got;
        int      mode;
        int      mode_left;
        int      run_left;
        bit      run_high;
        mode = 0;
        mode_left = 0;
        run_left = 0;
        run_high = 1'b0;
        result_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && !result_stall)
            begin
                got = make_result(send_valid, out_seq_number, out_checksum,
                                  msg_t'({out_payload_high, out_payload_mid,
                                          out_payload_low}),
                                  timer_t'(timer_action));
                got.drop = dropped;
                if (expected_results.size() == 0)
                    report_mismatch("result with nothing expected", got.msg.low, '0);
                else
                    check_result(got, expected_results.pop_front());
            end
            // switch between free flow, scattered stalls and long stall runs
            if (mode_left == 0)
            begin
                mode = $urandom_range(0, 2);
                mode_left = $urandom_range(20, 150);
            end
            mode_left--;
            case (mode)
                0: result_stall <= 1'b0;
                1: result_stall <= ($urandom_range(0, 2) == 0);
                default:
                begin
                    if (run_left == 0)
                    begin
                        run_high = ~run_high;
                        run_left = run_high ? $urandom_range(1, 25) : $urandom_range(1, 8);
                    end
                    run_left--;
                    result_stall <= run_high;
                end
            endcase
        end
    end

    // watchdog: too long without any transfer means the block hung
    always @(posedge clk)
    begin
        if ((event_valid && !event_stall) || (result_valid && !result_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == IDLE_LIMIT)
        begin
            $display("timeout after %0d cycles without a transfer", IDLE_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        msg_t   ones;
        msg_t   r1;
        msg_t   r2;
        event_t ev;
        int     segment;

        ones = '1;
        r1 = {$urandom, $urandom, $urandom, $urandom, $urandom};
        r2 = {$urandom, $urandom, $urandom, $urandom, $urandom};

        cur_bit = 1'b0;
        in_flight = 1'b0;
        last_bit = 1'b0;
        last_sum = '0;
        last_msg = '0;

        rst_n = 1'b0;
        event_valid = 1'b0;
        func = FUNC_MESSAGE;
        payload_low = '0;
        payload_mid = '0;
        payload_high = '0;
        in_seq_number = '0;
        in_ack_number = '0;
        in_checksum = '0;

        // directed table, bit state noted after each row
        // expiry right after reset resends the all-zero packet
        add_row(FUNC_EXPIRY, '0, 0, 0, 0, 0, 1,
                make_result(1, 0, 0, '0, TIMER_START));
        // good ack with nothing queued: stop, bit goes to 1
        add_row(FUNC_PACKET, '0, 0, 0, 0, 0, 1,
                make_result(0, 0, 0, '0, TIMER_STOP));
        // message while idle goes out at once, largest checksum
        add_row(FUNC_MESSAGE, ones, 0, 0, 0, 0, 1,
                make_result(1, 1, 13'd5101, ones, TIMER_START));
        // messages while waiting are only queued
        add_row(FUNC_MESSAGE, '0, 0, 0, 0, 0, 1,
                make_result(0, 0, 0, '0, TIMER_NONE));
        add_row(FUNC_MESSAGE, r1, $urandom, $urandom, $urandom, 0, 0, '0);
        // corrupt checksum is ignored
        add_row(FUNC_PACKET, ones, 0, 1, 0, 0, 1,
                make_result(0, 0, 0, '0, TIMER_NONE));
        // clean packet with the wrong ack bit
        add_row(FUNC_PACKET, '0, 0, 0, 0, 0, 1,
                make_result(0, 0, 0, '0, TIMER_NONE));
        // checksum wraps to zero, ack field far out of range
        add_row(FUNC_PACKET, '0, 32'h8000_0000, 32'h8000_0000, 0, 0, 1,
                make_result(0, 0, 0, '0, TIMER_NONE));
        // good ack with a message queued: next one out, bit back to 0
        add_row(FUNC_PACKET, '0, 32'h7FFF_FFFF, 1, 32'h8000_0000, 0, 1,
                make_result(1, 0, 0, '0, TIMER_RESTART));
        // expiry ignores its payload
        add_row(FUNC_EXPIRY, r2, $urandom, $urandom, $urandom, 0, 1,
                make_result(1, 0, 0, '0, TIMER_START));
        add_row(FUNC_PACKET, random_msg(), $urandom, 0, 0, 1, 0, '0);
        add_row(FUNC_EXPIRY, '0, 0, 0, 0, 0, 0, '0);
        // good ack, queue drained, bit back to 0
        add_row(FUNC_PACKET, ones, 32'hFFFF_FFFF, 1, 0, 1, 1,
                make_result(0, 0, 0, '0, TIMER_STOP));
        add_row(FUNC_UNKNOWN, ones, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 1,
                make_result(0, 0, 0, '0, TIMER_NONE));
        // good ack while nothing is in flight still flips the bit
        add_row(FUNC_PACKET, '0, 0, 0, 0, 0, 1,
                make_result(0, 0, 0, '0, TIMER_STOP));
        add_row(FUNC_MESSAGE, r2, 0, 0, 0, 0, 0, '0);
        add_row(FUNC_PACKET, random_msg(), 32'h8000_0000, 1, 0, 1, 1,
                make_result(0, 0, 0, '0, TIMER_STOP));
        add_row(FUNC_EXPIRY, '0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, '0);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            ev = directed_rows[i].ev;
            if (directed_rows[i].fix_chk)
                ev.chk = good_checksum(ev);
            run_item(ev, directed_rows[i].typed, directed_rows[i].want);
        end

        // random part in segments: everyday mix, queue floods, ack drains
        while (accepted_items < ITEMS)
        begin
            segment = $urandom_range(0, 11);
            if (segment == 0)
            begin
                // enough messages to fill the queue and drop the rest
                repeat ($urandom_range(66, 80))
                    run_item(random_event(FUNC_MESSAGE), 0, '0);
            end
            else if (segment <= 2)
            begin
                // acknowledge everything queued, then one more
                repeat (pending_msgs.size() + 2)
                    run_item(good_ack_event(cur_bit), 0, '0);
            end
            else
            begin
                repeat ($urandom_range(10, 40))
                    run_item(mixed_event(), 0, '0);
            end
        end
        event_valid <= 1'b0;

        while (expected_results.size() != 0) @(posedge clk);
        // catch any extra result the block might still push out
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/abs_pkg.sv
rtl/core/abs_queue_mem.sv
rtl/core/alternating_bit_sender.sv
rtl/core/abs_checker.sv
tb/tb_top.sv
